// File: design/bdeque_pkg.sv
// ----------------------------------------------------------------------------
// bdeque_pkg
// Shared types and constants for the bounded deque with indexed read.
// ----------------------------------------------------------------------------
package bdeque_pkg;

    localparam int ELEM_W  = 32;
    localparam int CMD_W   = 3;
    localparam int POS_W   = 8;
    localparam int COUNT_W = 9;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_HEAD = 3'd0,
        CMD_INS_TAIL = 3'd1,
        CMD_RM_HEAD  = 3'd2,
        CMD_RM_TAIL  = 3'd3,
        CMD_RD_HEAD  = 3'd4,
        CMD_RD_TAIL  = 3'd5,
        CMD_RD_POS   = 3'd6
    } cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ELEM_W-1:0] element_in;
        logic [POS_W-1:0]  position;
    } request_t;

    typedef struct packed {
        logic [ELEM_W-1:0]  element_out;
        logic               found;
        logic [COUNT_W-1:0] count;
        logic               refused;
    } result_t;

    typedef struct packed {
        logic push_head;
        logic push_tail;
        logic pop_head;
        logic lane_load;
    } cell_ctrl_t;

endpackage

// File: design/bounded_array_list_deque_core.sv
// ----------------------------------------------------------------------------
// bounded_array_list_deque_core
// Bounded deque of words kept in a row of cells, with head/tail/indexed read.
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  request   start / busy     request (command, element_in, position)
//  result    done (strobe)    result (element_out, found, count, refused)
//
//  inserts, removals, unknown codes and reads that miss: result in the cycle
//  after acceptance, busy stays low, a new word every cycle.
//  a read that hits position p: busy while the word walks the read lane
//  from cell p down to cell 0; the result is on the ports in the first
//  cycle with busy low, when the next word can be taken.
//  reset clears the count and the controller; cell contents are left as is.
//  results cannot be stalled.
// ----------------------------------------------------------------------------
module bounded_array_list_deque_core #(
    parameter int CAPACITY = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  bdeque_pkg::request_t request,
    output logic                 done,
    output bdeque_pkg::result_t  result
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > bdeque_pkg::POS_W) ? CW : bdeque_pkg::POS_W;

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [IW-1:0]                 wait_reg;
    logic [IW-1:0]                 wait_next;
    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic                          done_reg;
    logic                          done_next;
    bdeque_pkg::result_t           result_reg;
    bdeque_pkg::result_t           result_next;

    bdeque_pkg::cell_ctrl_t        ctrl;
    logic [IW-1:0]                 sel;
    logic                          accept;
    logic                          nonempty;
    logic                          full;
    logic                          hit;
    logic                          refused;
    logic [CW-1:0]                 count_dec;

    logic [bdeque_pkg::ELEM_W-1:0] elem_w [CAPACITY];
    logic [bdeque_pkg::ELEM_W-1:0] lane_w [CAPACITY];

    assign accept    = start && (state_reg == S_IDLE);
    assign nonempty  = (count_reg != '0);
    assign full      = (count_reg == CW'(CAPACITY));
    assign count_dec = count_reg - CW'(1);

    always_comb
    begin
        ctrl       = '0;
        sel        = '0;
        hit        = 1'b0;
        refused    = 1'b0;
        count_next = count_reg;
        if (accept)
        begin
            unique case (request.command)
                bdeque_pkg::CMD_INS_HEAD:
                begin
                    if (full)
                    begin
                        refused = 1'b1;
                    end
                    else
                    begin
                        ctrl.push_head = 1'b1;
                        count_next     = count_reg + CW'(1);
                    end
                end
                bdeque_pkg::CMD_INS_TAIL:
                begin
                    if (full)
                    begin
                        refused = 1'b1;
                    end
                    else
                    begin
                        ctrl.push_tail = 1'b1;
                        sel            = count_reg[IW-1:0];
                        count_next     = count_reg + CW'(1);
                    end
                end
                bdeque_pkg::CMD_RM_HEAD:
                begin
                    if (nonempty)
                    begin
                        ctrl.pop_head = 1'b1;
                        count_next    = count_dec;
                    end
                end
                bdeque_pkg::CMD_RM_TAIL:
                begin
                    if (nonempty)
                    begin
                        count_next = count_dec;
                    end
                end
                bdeque_pkg::CMD_RD_HEAD:
                begin
                    hit = nonempty;
                end
                bdeque_pkg::CMD_RD_TAIL:
                begin
                    hit = nonempty;
                    sel = count_dec[IW-1:0];
                end
                bdeque_pkg::CMD_RD_POS:
                begin
                    hit = (PW'(request.position) < PW'(count_reg));
                    sel = IW'(request.position);
                end
                default:
                begin
                    hit = 1'b0;
                end
            endcase
            ctrl.lane_load = hit;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        wait_next   = wait_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    result_next.element_out = '0;
                    result_next.found       = 1'b0;
                    result_next.count       = bdeque_pkg::COUNT_W'(count_next);
                    result_next.refused     = refused;
                    if (hit)
                    begin
                        state_next = S_READ;
                        wait_next  = sel;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                if (wait_reg == '0)
                begin
                    state_next              = S_IDLE;
                    done_next               = 1'b1;
                    result_next.element_out = lane_w[0];
                    result_next.found       = 1'b1;
                end
                else
                begin
                    wait_next = wait_reg - IW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            wait_reg   <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            wait_reg   <= wait_next;
            count_reg  <= count_next;
            done_reg   <= done_next;
            result_reg <= result_next;
        end
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic [bdeque_pkg::ELEM_W-1:0] left_word;
            logic [bdeque_pkg::ELEM_W-1:0] right_word;
            logic [bdeque_pkg::ELEM_W-1:0] lane_in;

            if (i == 0)
            begin : g_first
                assign left_word = request.element_in;
            end
            else
            begin : g_mid
                assign left_word = elem_w[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_word = '0;
                assign lane_in    = '0;
            end
            else
            begin : g_inner
                assign right_word = elem_w[i+1];
                assign lane_in    = lane_w[i+1];
            end

            bdeque_cell #(
                .IDX (i),
                .IW  (IW)
            ) u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .sel        (sel),
                .new_word   (request.element_in),
                .left_word  (left_word),
                .right_word (right_word),
                .lane_in    (lane_in),
                .element    (elem_w[i]),
                .lane       (lane_w[i])
            );
        end
    endgenerate

    assign busy   = (state_reg == S_READ);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: design/bdeque_cell.sv
// ----------------------------------------------------------------------------
// bdeque_cell
// One list slot: holds an element and one stage of the read lane.
// ----------------------------------------------------------------------------
module bdeque_cell #(
    parameter int IDX = 0,
    parameter int IW  = 8
) (
    input  logic                           clk,
    input  bdeque_pkg::cell_ctrl_t         ctrl,
    input  logic [IW-1:0]                  sel,
    input  logic [bdeque_pkg::ELEM_W-1:0]  new_word,
    input  logic [bdeque_pkg::ELEM_W-1:0]  left_word,
    input  logic [bdeque_pkg::ELEM_W-1:0]  right_word,
    input  logic [bdeque_pkg::ELEM_W-1:0]  lane_in,
    output logic [bdeque_pkg::ELEM_W-1:0]  element,
    output logic [bdeque_pkg::ELEM_W-1:0]  lane
);

    logic [bdeque_pkg::ELEM_W-1:0] elem_reg;
    logic [bdeque_pkg::ELEM_W-1:0] elem_next;
    logic [bdeque_pkg::ELEM_W-1:0] lane_reg;
    logic [bdeque_pkg::ELEM_W-1:0] lane_next;
    logic                          hit;

    assign hit = (sel == IW'(IDX));

    always_comb
    begin
        elem_next = elem_reg;
        if (ctrl.push_head)
        begin
            elem_next = (IDX == 0) ? new_word : left_word;
        end
        else if (ctrl.pop_head)
        begin
            elem_next = right_word;
        end
        else if (ctrl.push_tail && hit)
        begin
            elem_next = new_word;
        end
        lane_next = (ctrl.lane_load && hit) ? elem_reg : lane_in;
    end

    always_ff @(posedge clk)
    begin
        elem_reg <= elem_next;
        lane_reg <= lane_next;
    end

    assign element = elem_reg;
    assign lane    = lane_reg;

endmodule

// File: design/bdeque_checker.sv
// ----------------------------------------------------------------------------
// bdeque_checker
// Port-level checks on the deque core, attached by bind.
// ----------------------------------------------------------------------------
module bdeque_checker #(
    parameter int CAPACITY = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  bdeque_pkg::request_t request,
    input  logic                 done,
    input  bdeque_pkg::result_t  result
);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (32'(result.count) <= 32'(CAPACITY)))
        else $error("count above capacity");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.found) |-> (result.element_out == '0))
        else $error("element on a miss");

    a_refuse_full: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.refused) |-> (32'(result.count) == 32'(CAPACITY)) && !result.found)
        else $error("refusal while not full");

    a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (request.command == bdeque_pkg::CMD_INS_HEAD
            || request.command == bdeque_pkg::CMD_INS_TAIL
            || request.command == bdeque_pkg::CMD_RM_HEAD
            || request.command == bdeque_pkg::CMD_RM_TAIL)) |=> (done && !busy))
        else $error("missing result after update");

    a_busy_rise: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy without a word");

endmodule

bind bounded_array_list_deque_core bdeque_checker #(
    .CAPACITY (CAPACITY)
) u_bdeque_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .request (request),
    .done    (done),
    .result  (result)
);
